FILE: hw/rtl/ffra_pkg.sv
`default_nettype none

package ffra_pkg;

    // Fixed widths of the item fields
    localparam int unsigned FIELD_W    = 24;
    localparam int unsigned STATUS_W   = 3;
    // Widest cell index for the largest supported table
    localparam int unsigned POS_MAX_W  = 10;

    // Defaults of the top-level parameters
    localparam int unsigned MAX_ENTRIES_DEF = 64;
    localparam int unsigned ADDR_BITS_DEF   = 24;

    // Reset value of the capacity register
    localparam logic [FIELD_W-1:0] CAP_RESET = 24'hFFFFFF;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SIZE_MISMATCH = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE     = 3'd5;

    // Request type codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EDIT,
        S_RESP
    } state_t;

    // What every cell of the chain does this cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROT,
        OP_INS,
        OP_DEL
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [POS_MAX_W-1:0]   pos;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffra_cell.sv
`default_nettype none

module ffra_cell #(
    parameter int unsigned AW  = ffra_pkg::ADDR_BITS_DEF,
    parameter int unsigned IDX = 0
) (
    input  wire logic               clk,
    input  wire ffra_pkg::cell_ctl_t ctl,
    input  wire logic [AW-1:0]      left_start,
    input  wire logic [AW-1:0]      left_len,
    input  wire logic [AW-1:0]      right_start,
    input  wire logic [AW-1:0]      right_len,
    input  wire logic [AW-1:0]      new_start,
    input  wire logic [AW-1:0]      new_len,
    output logic [AW-1:0]           start,
    output logic [AW-1:0]           len
);

    localparam logic [ffra_pkg::POS_MAX_W-1:0] MY_IDX = ffra_pkg::POS_MAX_W'(IDX);

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] len_reg, len_next;

    // Pick the source of this entry: keep, neighbor or new range
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        case (ctl.op)
            ffra_pkg::OP_ROT:
            begin
                start_next = right_start;
                len_next   = right_len;
            end
            ffra_pkg::OP_INS:
            begin
                if (MY_IDX > ctl.pos)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                end
                else if (MY_IDX == ctl.pos)
                begin
                    start_next = new_start;
                    len_next   = new_len;
                end
            end
            ffra_pkg::OP_DEL:
            begin
                if (MY_IDX >= ctl.pos)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            default:
            begin
                start_next = start_reg;
                len_next   = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign start = start_reg;
    assign len   = len_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/first_fit_range_allocator_core.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   req_type, size, start_offset
// out       output     out_valid / out_stall status, granted_offset
// cfg       input      cfg_valid / cfg_ready cfg_data (total_capacity)
//
// One item at a time. A zero-size or table-full allocate goes to the response
// state without a scan; every other item first makes one full rotation of the
// entry ring through the head cell.
// Reset empties the table at once (entry count to zero) and sets the
// capacity to its maximum. A stalled result holds the block in its
// response state; in_stall stays high until the result is taken.
module first_fit_range_allocator_core #(
    parameter int unsigned MAX_ENTRIES = ffra_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [ffra_pkg::FIELD_W-1:0]  size,
    input  wire logic [ffra_pkg::FIELD_W-1:0]  start_offset,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ffra_pkg::STATUS_W-1:0]      status,
    output logic [ffra_pkg::FIELD_W-1:0]       granted_offset,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ffra_pkg::FIELD_W-1:0]  cfg_data
);

    localparam int unsigned N    = MAX_ENTRIES;
    localparam int unsigned AW   = ADDR_BITS;
    localparam int unsigned IW   = $clog2(N);
    localparam int unsigned CNTW = $clog2(N + 1);
    localparam int unsigned CW   = ((AW > ffra_pkg::FIELD_W) ? AW : ffra_pkg::FIELD_W) + 1;

    ffra_pkg::state_t state_reg, state_next;

    logic [ffra_pkg::FIELD_W-1:0]  cap_reg, cap_next;
    logic [CNTW-1:0]               count_reg, count_next;
    logic [IW-1:0]                 step_reg, step_next;
    logic [IW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 cand_reg, cand_next;
    logic                          found_reg, found_next;
    logic                          mism_reg, mism_next;
    logic                          req_reg, req_next;
    logic [ffra_pkg::FIELD_W-1:0]  size_reg, size_next;
    logic [ffra_pkg::FIELD_W-1:0]  off_reg, off_next;
    logic [ffra_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ffra_pkg::FIELD_W-1:0]  grant_reg, grant_next;

    ffra_pkg::cell_ctl_t ctl;
    logic [AW-1:0] cs [N];
    logic [AW-1:0] cl [N];
    logic [AW-1:0] new_start, new_len;

    // Head cell view used by the scan
    logic          head_valid, fit, last_step;
    logic [CW-1:0] head_start, head_len, cap_ext, size_ext, limit;

    // Chain of entry cells; the last one wraps to the head for rotation
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ffra_cell #(
            .AW  (AW),
            .IDX (k)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_start  ((k == 0) ? new_start : cs[(k + N - 1) % N]),
            .left_len    ((k == 0) ? new_len   : cl[(k + N - 1) % N]),
            .right_start (cs[(k + 1) % N]),
            .right_len   (cl[(k + 1) % N]),
            .new_start   (new_start),
            .new_len     (new_len),
            .start       (cs[k]),
            .len         (cl[k])
        );
    end

    assign new_start = AW'(cand_reg);
    assign new_len   = AW'(size_reg);

    // Gap test at the head cell
    always_comb
    begin
        head_valid = CNTW'(step_reg) < count_reg;
        head_start = CW'(cs[0]);
        head_len   = CW'(cl[0]);
        cap_ext    = CW'(cap_reg);
        size_ext   = CW'(size_reg);
        if (head_valid && (head_start < cap_ext))
            limit = head_start;
        else
            limit = cap_ext;
        fit       = (cand_reg <= limit) && (size_ext <= limit - cand_reg);
        last_step = step_reg == IW'(N - 1);
    end

    // Next state, scan bookkeeping and result
    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        found_next  = found_reg;
        mism_next   = mism_reg;
        req_next    = req_reg;
        size_next   = size_reg;
        off_next    = off_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        ctl.op      = ffra_pkg::OP_HOLD;
        ctl.pos     = ffra_pkg::POS_MAX_W'(pos_reg);

        if (cfg_valid)
            cap_next = cfg_data;

        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    size_next  = size;
                    off_next   = start_offset;
                    step_next  = '0;
                    cand_next  = '0;
                    found_next = 1'b0;
                    mism_next  = 1'b0;
                    grant_next = '0;
                    if ((req_type == ffra_pkg::REQ_ALLOC) && (size == '0))
                    begin
                        status_next = ffra_pkg::STAT_ZERO_SIZE;
                        state_next  = ffra_pkg::S_RESP;
                    end
                    else if ((req_type == ffra_pkg::REQ_ALLOC) &&
                             (count_reg >= CNTW'(N)))
                    begin
                        status_next = ffra_pkg::STAT_TABLE_FULL;
                        state_next  = ffra_pkg::S_RESP;
                    end
                    else
                        state_next = ffra_pkg::S_SCAN;
                end
            end
            ffra_pkg::S_SCAN:
            begin
                // Rotate the ring one cell and test the entry at the head
                ctl.op = ffra_pkg::OP_ROT;
                if (!found_reg)
                begin
                    if (req_reg == ffra_pkg::REQ_ALLOC)
                    begin
                        if ((CNTW'(step_reg) <= count_reg) && fit)
                        begin
                            found_next = 1'b1;
                            pos_next   = step_reg;
                        end
                        else if (head_valid)
                            cand_next = head_start + head_len;
                    end
                    else if (head_valid && (head_start == CW'(off_reg)))
                    begin
                        found_next = 1'b1;
                        pos_next   = step_reg;
                        mism_next  = head_len != size_ext;
                    end
                end
                step_next = step_reg + IW'(1);
                if (last_step)
                begin
                    state_next = ffra_pkg::S_RESP;
                    if (req_reg == ffra_pkg::REQ_ALLOC)
                    begin
                        if (found_next)
                        begin
                            status_next = ffra_pkg::STAT_OK;
                            grant_next  = ffra_pkg::FIELD_W'(cand_next);
                            state_next  = ffra_pkg::S_EDIT;
                        end
                        else
                            status_next = ffra_pkg::STAT_NO_SPACE;
                    end
                    else if (!found_next)
                        status_next = ffra_pkg::STAT_NOT_FOUND;
                    else if (mism_next)
                        status_next = ffra_pkg::STAT_SIZE_MISMATCH;
                    else
                    begin
                        status_next = ffra_pkg::STAT_OK;
                        state_next  = ffra_pkg::S_EDIT;
                    end
                end
            end
            ffra_pkg::S_EDIT:
            begin
                // Open or close a slot at the found position
                if (req_reg == ffra_pkg::REQ_ALLOC)
                begin
                    ctl.op     = ffra_pkg::OP_INS;
                    count_next = count_reg + CNTW'(1);
                end
                else
                begin
                    ctl.op     = ffra_pkg::OP_DEL;
                    count_next = count_reg - CNTW'(1);
                end
                state_next = ffra_pkg::S_RESP;
            end
            ffra_pkg::S_RESP:
            begin
                if (!out_stall)
                    state_next = ffra_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffra_pkg::S_IDLE;
            cap_reg   <= ffra_pkg::CAP_RESET;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            count_reg <= count_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        pos_reg    <= pos_next;
        cand_reg   <= cand_next;
        found_reg  <= found_next;
        mism_reg   <= mism_next;
        req_reg    <= req_next;
        size_reg   <= size_next;
        off_reg    <= off_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    assign in_stall       = state_reg != ffra_pkg::S_IDLE;
    assign out_valid      = state_reg == ffra_pkg::S_RESP;
    assign status         = status_reg;
    assign granted_offset = grant_reg;
    assign cfg_ready      = 1'b1;

endmodule

`default_nettype wire
